// ===== design/color_gradient_lookup_table_unit_defines.svh =====
// Assertion macros for the gradient lookup unit checker.
// No dependencies; included by the checker file only.
`ifndef COLOR_GRADIENT_LOOKUP_TABLE_UNIT_DEFINES_SVH
`define COLOR_GRADIENT_LOOKUP_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define CGLUT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CGLUT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cglut_pkg.sv =====
// Shared types and constants for the gradient lookup unit.
// No dependencies.
package cglut_pkg;

	localparam int CH_W        = 16;
	localparam int POS_W       = 16;
	localparam int IDX_W       = 12;
	localparam int QPOS_W      = 27;     // entry_index * 32768 fits here
	localparam int DIV_W       = 32;     // serial divider dividend width
	localparam int CNT_W       = 9;      // holds a stop count up to 256
	localparam int DEF_MAX_COLOR_STOPS   = 16;
	localparam int DEF_MAX_OPACITY_STOPS = 16;
	localparam logic [IDX_W-1:0] LAST_INDEX_RST = 12'd255;

	localparam logic [1:0] KIND_LOAD_COLOR   = 2'd0;
	localparam logic [1:0] KIND_LOAD_OPACITY = 2'd1;
	localparam logic [1:0] KIND_CLEAR        = 2'd2;
	localparam logic [1:0] KIND_LOOKUP       = 2'd3;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_NO_COLOR   = 2'd2;
	localparam logic [1:0] STAT_NO_OPACITY = 2'd3;

	localparam logic REG_LAST_INDEX = 1'b0;

	typedef struct packed {
		logic [1:0]       kind;
		logic [POS_W-1:0] stop_position;
		logic [CH_W-1:0]  stop_red;
		logic [CH_W-1:0]  stop_green;
		logic [CH_W-1:0]  stop_blue;
		logic [CH_W-1:0]  stop_opacity;
		logic [IDX_W-1:0] entry_index;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_opacity;
		logic [1:0]      status;
	} out_item_t;

	typedef struct packed {
		logic             latch;
		logic             clear;
		logic             pos_start;
		logic             div_step;
		logic             pos_save;
		logic             rd_en;
		logic [CNT_W-1:0] rd_addr;
		logic             tsel;       // 0 colour table, 1 opacity table
		logic             scan_clr;
		logic             ld_commit;
		logic             mul;
		logic             ch_save;
		logic [1:0]       ch;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] col_used;
		logic [CNT_W-1:0] opa_used;
	} sts_t;

endpackage

// ===== design/color_gradient_lookup_table_unit.sv =====
// Gradient lookup unit: top level. From accept to result valid: a clear goes straight to
// the result; a load scans the stored stops, then writes; a lookup runs the position
// division, a scan per stocked table, then per channel a multiply and a division (four when
// both tables are stocked) on the shared 32-step bit-serial divider. One item at a time: the
// next is taken in the same cycle the result rises, so the divider bounds the lookup rate.
// Reset empties both tables (fill counts to zero, storage kept) and sets last_index to 255.
module color_gradient_lookup_table_unit #(
	parameter int MAX_COLOR_STOPS   = cglut_pkg::DEF_MAX_COLOR_STOPS,
	parameter int MAX_OPACITY_STOPS = cglut_pkg::DEF_MAX_OPACITY_STOPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// item input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  cglut_pkg::in_item_t  in_item,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output cglut_pkg::out_item_t out_item
);

	logic [cglut_pkg::IDX_W-1:0] last_index_q;
	cglut_pkg::cmd_t             cmd;
	cglut_pkg::sts_t             sts;

	// register file: only last_index; word address taken from paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cglut_pkg::REG_LAST_INDEX) ?
	                32'(last_index_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= cglut_pkg::LAST_INDEX_RST;
		end else if (psel && penable && pwrite &&
		             paddr[2] == cglut_pkg::REG_LAST_INDEX) begin
			last_index_q <= pwdata[cglut_pkg::IDX_W-1:0];
		end
	end

	// sequencer: owns the handshakes and steps the datapath
	cglut_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_kind   (in_item.kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, search registers, divider and output register
	cglut_dp #(
		.MAX_COLOR_STOPS   (MAX_COLOR_STOPS),
		.MAX_OPACITY_STOPS (MAX_OPACITY_STOPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.last_index (last_index_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_item   (out_item)
	);

endmodule

// ===== design/cglut_ctrl.sv =====
// Sequencer for the gradient lookup unit: scans, divider steps, output.
// Depends on cglut_pkg.
module cglut_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            in_kind,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cglut_pkg::sts_t       sts,
	output cglut_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LD_SCAN, ST_LD_WR, ST_POS_DIV, ST_POS_SAVE,
		ST_SCAN_START, ST_SCAN, ST_MUL, ST_DIV, ST_CH_SAVE, ST_OUT
	} state_t;

	localparam logic [cglut_pkg::CNT_W-1:0] LAST_STEP =
		cglut_pkg::CNT_W'(cglut_pkg::DIV_W - 1);

	state_t                      state_q;
	logic [cglut_pkg::CNT_W-1:0] cnt_q;
	logic                        pend_q;
	logic                        tsel_q;
	logic [1:0]                  ch_q;
	logic                        out_valid_q;
	logic [cglut_pkg::CNT_W-1:0] n;
	logic                        more;
	logic                        accept;
	logic                        out_free;

	assign n        = tsel_q ? sts.opa_used : sts.col_used;
	assign more     = cnt_q < n;
	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && state_q == ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.rd_addr   = cnt_q;
		cmd.tsel      = tsel_q;
		cmd.ch        = ch_q;
		cmd.latch     = accept;
		cmd.clear     = accept && in_kind == cglut_pkg::KIND_CLEAR;
		cmd.pos_start = accept && in_kind == cglut_pkg::KIND_LOOKUP;
		unique case (state_q) inside
			ST_LD_SCAN, ST_SCAN: cmd.rd_en = more;
			ST_LD_WR:            cmd.ld_commit = 1'b1;
			ST_POS_DIV, ST_DIV:  cmd.div_step = 1'b1;
			ST_POS_SAVE:         cmd.pos_save = 1'b1;
			ST_SCAN_START:       cmd.scan_clr = 1'b1;
			ST_MUL:              cmd.mul = 1'b1;
			ST_CH_SAVE:          cmd.ch_save = 1'b1;
			ST_OUT:              cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			tsel_q      <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a result leaving while the next one is raised keeps valid high
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q) inside
				ST_IDLE: begin
					cnt_q  <= '0;
					pend_q <= 1'b0;
					if (in_valid) begin
						unique case (in_kind) inside
							cglut_pkg::KIND_LOAD_COLOR, cglut_pkg::KIND_LOAD_OPACITY: begin
								tsel_q  <= in_kind[0];
								state_q <= ST_LD_SCAN;
							end
							cglut_pkg::KIND_CLEAR: state_q <= ST_OUT;
							default:               state_q <= ST_POS_DIV;
						endcase
					end
				end
				ST_LD_SCAN, ST_SCAN: begin
					pend_q <= more;
					if (more)
						cnt_q <= cnt_q + 1'b1;
					else if (!pend_q)
						state_q <= (state_q == ST_LD_SCAN) ? ST_LD_WR : ST_MUL;
				end
				ST_LD_WR: state_q <= ST_OUT;
				ST_POS_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP)
						state_q <= ST_POS_SAVE;
				end
				ST_POS_SAVE: begin
					tsel_q  <= 1'b0;
					state_q <= ST_SCAN_START;
				end
				ST_SCAN_START: begin
					cnt_q  <= '0;
					pend_q <= 1'b0;
					ch_q   <= tsel_q ? 2'd3 : 2'd0;
					if (n != '0)
						state_q <= ST_SCAN;
					else if (!tsel_q)
						tsel_q <= 1'b1;
					else
						state_q <= ST_OUT;
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP)
						state_q <= ST_CH_SAVE;
				end
				ST_CH_SAVE: begin
					unique case (ch_q)
						2'd2: begin
							tsel_q  <= 1'b1;
							state_q <= ST_SCAN_START;
						end
						2'd3:    state_q <= ST_OUT;
						default: begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_MUL;
						end
					endcase
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/cglut_dp.sv =====
// Datapath of the gradient lookup unit: stop tables, bracket search,
// multiplier and bit-serial divider, result register. Depends on cglut_pkg.
module cglut_dp #(
	parameter int MAX_COLOR_STOPS   = cglut_pkg::DEF_MAX_COLOR_STOPS,
	parameter int MAX_OPACITY_STOPS = cglut_pkg::DEF_MAX_OPACITY_STOPS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cglut_pkg::in_item_t    in_item,
	input  logic [cglut_pkg::IDX_W-1:0] last_index,
	input  cglut_pkg::cmd_t        cmd,
	output cglut_pkg::sts_t        sts,
	output cglut_pkg::out_item_t   out_item
);

	localparam int CAW = $clog2(MAX_COLOR_STOPS);
	localparam int OAW = $clog2(MAX_OPACITY_STOPS);
	localparam int CW  = cglut_pkg::CH_W;
	localparam int PW  = cglut_pkg::POS_W;
	localparam int NW  = cglut_pkg::CNT_W;
	localparam int DW  = cglut_pkg::DIV_W;
	localparam int IDX_W_L = cglut_pkg::IDX_W;
	localparam logic [NW-1:0] COL_CAP = NW'(MAX_COLOR_STOPS);
	localparam logic [NW-1:0] OPA_CAP = NW'(MAX_OPACITY_STOPS);

	logic [PW+3*CW-1:0] col_mem [MAX_COLOR_STOPS];
	logic [PW+CW-1:0]   opa_mem [MAX_OPACITY_STOPS];
	logic [PW+3*CW-1:0] col_rd_q;
	logic [PW+CW-1:0]   opa_rd_q;
	logic               rd_vld_q, rd_tsel_q;
	logic [NW-1:0]      rd_idx_q;

	cglut_pkg::in_item_t item_q;
	logic [NW-1:0]       col_used_q, opa_used_q;
	logic                hit_q;
	logic [NW-1:0]       hit_idx_q;
	logic                eq_q, lo_q, hi_q;
	logic [3*CW-1:0]     eq_val_q, lo_val_q, hi_val_q;
	logic [PW-1:0]       lo_key_q, hi_key_q;
	logic [cglut_pkg::QPOS_W-1:0] pos_q;
	logic [DW-1:0]       dvd_q;
	logic [CW:0]         rem_q;
	logic [CW-1:0]       dsr_q;
	logic                neg_q;
	logic [3:0][CW-1:0]  res_q;
	logic [1:0]          stat_q;
	cglut_pkg::out_item_t out_q;

	logic [PW-1:0]       key_r;
	logic [3*CW-1:0]     val_r;
	logic [cglut_pkg::QPOS_W-1:0] key_ext;
	logic [CW:0]         rem_n;
	logic                ge;
	logic [CW-1:0]       ca, cb, mag, tdist, q16, v;
	logic [3*CW-1:0]     wval;
	logic [IDX_W_L-1:0]  div_eff;

	function automatic logic [CW-1:0] chan(input logic [3*CW-1:0] val, input logic [1:0] c);
		logic [CW-1:0] r;
		case (c)
			2'd0:    r = val[3*CW-1:2*CW];
			2'd1:    r = val[2*CW-1:CW];
			default: r = val[CW-1:0];
		endcase
		return r;
	endfunction

	assign sts.col_used = col_used_q;
	assign sts.opa_used = opa_used_q;
	assign out_item     = out_q;

	// read data of the last issued table read
	assign key_r   = rd_tsel_q ? opa_rd_q[PW+CW-1:CW] : col_rd_q[PW+3*CW-1:3*CW];
	assign val_r   = rd_tsel_q ? {{(2*CW){1'b0}}, opa_rd_q[CW-1:0]} : col_rd_q[3*CW-1:0];
	assign key_ext = cglut_pkg::QPOS_W'(key_r);

	assign rem_n = {rem_q[CW-1:0], dvd_q[DW-1]};
	assign ge    = rem_n >= {1'b0, dsr_q};

	assign ca    = chan(lo_val_q, cmd.ch);
	assign cb    = chan(hi_val_q, cmd.ch);
	assign mag   = (cb >= ca) ? cb - ca : ca - cb;
	assign tdist = pos_q[PW-1:0] - lo_key_q;
	assign q16   = dvd_q[CW-1:0];
	assign div_eff = (last_index == '0) ? IDX_W_L'(1) : last_index;

	always_comb begin
		if (eq_q)
			v = chan(eq_val_q, cmd.ch);
		else if (!lo_q)
			v = cb;
		else if (!hi_q)
			v = ca;
		else
			v = neg_q ? ca - q16 : ca + q16;
	end

	assign wval = item_q.kind[0] ? {{(2*CW){1'b0}}, item_q.stop_opacity}
	                             : {item_q.stop_red, item_q.stop_green, item_q.stop_blue};

	// stop tables
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			col_rd_q <= col_mem[cmd.rd_addr[CAW-1:0]];
			opa_rd_q <= opa_mem[cmd.rd_addr[OAW-1:0]];
		end
		if (cmd.ld_commit && !item_q.kind[0]) begin
			if (hit_q)
				col_mem[hit_idx_q[CAW-1:0]] <= {item_q.stop_position, wval};
			else if (col_used_q < COL_CAP)
				col_mem[col_used_q[CAW-1:0]] <= {item_q.stop_position, wval};
		end
		if (cmd.ld_commit && item_q.kind[0]) begin
			if (hit_q)
				opa_mem[hit_idx_q[OAW-1:0]] <= {item_q.stop_position, wval[CW-1:0]};
			else if (opa_used_q < OPA_CAP)
				opa_mem[opa_used_q[OAW-1:0]] <= {item_q.stop_position, wval[CW-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_used_q <= '0;
			opa_used_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			rd_vld_q <= cmd.rd_en;
			if (cmd.clear) begin
				col_used_q <= '0;
				opa_used_q <= '0;
			end
			if (cmd.ld_commit && !hit_q) begin
				if (!item_q.kind[0] && col_used_q < COL_CAP)
					col_used_q <= col_used_q + 1'b1;
				if (item_q.kind[0] && opa_used_q < OPA_CAP)
					opa_used_q <= opa_used_q + 1'b1;
			end
		end
	end

	// item, search, arithmetic and result registers
	always_ff @(posedge clk) begin
		rd_tsel_q <= cmd.tsel;
		rd_idx_q  <= cmd.rd_addr;
		if (cmd.latch) begin
			item_q <= in_item;
			hit_q  <= 1'b0;
			res_q  <= '0;
			stat_q <= cglut_pkg::STAT_OK;
		end
		if (cmd.scan_clr) begin
			eq_q <= 1'b0;
			lo_q <= 1'b0;
			hi_q <= 1'b0;
		end
		if (rd_vld_q) begin
			if (key_r == item_q.stop_position) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_q;
			end
			if (key_ext == pos_q) begin
				eq_q     <= 1'b1;
				eq_val_q <= val_r;
			end else if (key_ext < pos_q) begin
				if (!lo_q || key_r > lo_key_q) begin
					lo_q     <= 1'b1;
					lo_key_q <= key_r;
					lo_val_q <= val_r;
				end
			end else if (!hi_q || key_r < hi_key_q) begin
				hi_q     <= 1'b1;
				hi_key_q <= key_r;
				hi_val_q <= val_r;
			end
		end
		if (cmd.pos_start) begin
			dvd_q <= DW'({in_item.entry_index, {PW-1{1'b0}}});
			dsr_q <= CW'(div_eff);
			rem_q <= '0;
		end else if (cmd.mul) begin
			dvd_q <= DW'(mag * tdist);
			dsr_q <= hi_key_q - lo_key_q;
			neg_q <= cb < ca;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_n - {1'b0, dsr_q} : rem_n;
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
		if (cmd.pos_save) begin
			pos_q <= dvd_q[cglut_pkg::QPOS_W-1:0];
			if (col_used_q == '0)
				stat_q <= cglut_pkg::STAT_NO_COLOR;
			else if (opa_used_q == '0)
				stat_q <= cglut_pkg::STAT_NO_OPACITY;
		end
		if (cmd.ld_commit && !hit_q &&
		    ((!item_q.kind[0] && col_used_q >= COL_CAP) ||
		     (item_q.kind[0] && opa_used_q >= OPA_CAP)))
			stat_q <= cglut_pkg::STAT_FULL;
		if (cmd.ch_save)
			res_q[cmd.ch] <= v;
		if (cmd.out_load) begin
			out_q.out_red     <= res_q[0];
			out_q.out_green   <= res_q[1];
			out_q.out_blue    <= res_q[2];
			out_q.out_opacity <= res_q[3];
			out_q.status      <= stat_q;
		end
	end

endmodule

// ===== design/cglut_checker.sv =====
// Port-level checker for the gradient lookup unit, bound to the top level.
// Depends on cglut_pkg and color_gradient_lookup_table_unit_defines.svh.
`include "color_gradient_lookup_table_unit_defines.svh"

module cglut_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input cglut_pkg::out_item_t out_item
);

	`CGLUT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
	`CGLUT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")
	`CGLUT_ASSERT_NOW(a_full_zero, out_valid && out_item.status == cglut_pkg::STAT_FULL, out_item.out_red == '0 && out_item.out_green == '0 && out_item.out_blue == '0 && out_item.out_opacity == '0, "full result not zero")
	`CGLUT_ASSERT_NOW(a_no_color_zero, out_valid && out_item.status == cglut_pkg::STAT_NO_COLOR, out_item.out_red == '0 && out_item.out_green == '0 && out_item.out_blue == '0, "empty colour table gave colour")

endmodule

bind color_gradient_lookup_table_unit cglut_checker u_cglut_checker (.*);
